// ===== rtl/cdlf_pkg.sv =====
// Shared types, constants and digit helpers for the clock/date LCD formatter.
package cdlf_pkg;

  // Input stream packing (lowest bit first)
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 8;

  // One snapshot after classification: digits ready for the display sequencer
  typedef struct packed {
    logic       is24;
    logic       pm;
    logic [3:0] hour_t;
    logic [3:0] hour_u;
    logic [3:0] min_t;
    logic [3:0] min_u;
    logic [3:0] sec_t;
    logic [3:0] sec_u;
    logic [3:0] day_t;
    logic [3:0] day_u;
    logic [3:0] mon_t;
    logic [3:0] mon_u;
    logic       century;
    logic [3:0] year_t;
    logic [3:0] year_u;
    logic       alarm;
  } rec_t;

  // LCD command and character codes
  localparam logic [7:0] CmdRow0   = 8'h80;
  localparam logic [7:0] CmdRow1   = 8'hC0;
  localparam logic [3:0] ColMask   = 4'hF;
  localparam logic [3:0] ColAmPm   = 4'd12;
  localparam logic [3:0] ColTime12 = 4'd3;
  localparam logic [3:0] ColTime24 = 4'd4;
  localparam logic [3:0] ColDate   = 4'd3;
  localparam logic [7:0] AsciiZero = 8'd48;
  localparam logic [7:0] ChA       = 8'h41;
  localparam logic [7:0] ChP       = 8'h50;
  localparam logic [7:0] ChM       = 8'h4D;
  localparam logic [7:0] ChColon   = 8'h3A;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChTwo     = 8'h32;
  localparam logic [4:0] HalfDay   = 5'd12;
  localparam logic [6:0] Century   = 7'd100;

  // Sequencer slots of one run
  localparam int unsigned StepW = 5;
  localparam logic [StepW-1:0] StepAmPmCursor = 5'd0;
  localparam logic [StepW-1:0] StepAmPm       = 5'd1;
  localparam logic [StepW-1:0] StepM          = 5'd2;
  localparam logic [StepW-1:0] StepTimeCursor = 5'd3;
  localparam logic [StepW-1:0] StepHourT      = 5'd4;
  localparam logic [StepW-1:0] StepHourU      = 5'd5;
  localparam logic [StepW-1:0] StepColon0     = 5'd6;
  localparam logic [StepW-1:0] StepMinT       = 5'd7;
  localparam logic [StepW-1:0] StepMinU       = 5'd8;
  localparam logic [StepW-1:0] StepColon1     = 5'd9;
  localparam logic [StepW-1:0] StepSecT       = 5'd10;
  localparam logic [StepW-1:0] StepSecU       = 5'd11;
  localparam logic [StepW-1:0] StepDateCursor = 5'd12;
  localparam logic [StepW-1:0] StepDayT       = 5'd13;
  localparam logic [StepW-1:0] StepDayU       = 5'd14;
  localparam logic [StepW-1:0] StepColon2     = 5'd15;
  localparam logic [StepW-1:0] StepMonT       = 5'd16;
  localparam logic [StepW-1:0] StepMonU       = 5'd17;
  localparam logic [StepW-1:0] StepColon3     = 5'd18;
  localparam logic [StepW-1:0] StepYearK      = 5'd19;
  localparam logic [StepW-1:0] StepYearC      = 5'd20;
  localparam logic [StepW-1:0] StepYearT      = 5'd21;
  localparam logic [StepW-1:0] StepYearU      = 5'd22;
  localparam logic [StepW-1:0] StepSpace0     = 5'd23;
  localparam logic [StepW-1:0] StepSpace1     = 5'd24;
  localparam logic [StepW-1:0] StepStar       = 5'd25;

  // Split a value below 100 into tens and units (reciprocal multiply by 205/2048)
  function automatic logic [7:0] pair_digits(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = 15'(v) * 15'd205;
    tens  = prod[14:11];
    units = v - 7'(tens) * 7'd10;
    return {tens, units[3:0]};
  endfunction

  // ASCII character of one decimal digit
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return AsciiZero + {4'b0000, d};
  endfunction

endpackage

// ===== rtl/clock_date_lcd_formatter.sv =====
// Top level of the clock/date LCD formatter: front end, snapshot queue, sequencer.
//
// Usage: each request on the s_axis channel is one time-and-date snapshot. The
// block answers with the HD44780-style byte run that shows it on the m_axis
// channel: tdata carries the byte, tuser is 1 for a character and 0 for a
// cursor command, tlast marks the final byte of the run.
// The one-bit hour format register is written through cfg_we_i/cfg_wdata_i
// (0 = 12-hour with AM/PM, 1 = 24-hour); write it only while no run is open.
// A request is written into the snapshot queue; the first byte of its run is then
// loaded from the queue head into the output register. A run is 23 or 26 bytes in
// 12-hour mode, 20 or 23 in 24-hour mode, the larger with the alarm marker; at one
// byte per cycle, unless the receiver stalls, the count sets the sustained rate.
// Requests keep being accepted while a run is emitted until the snapshot queue
// is full.
// Reset clears the format register to 12-hour mode and empties the queue and
// output register. When the receiver stalls, the output byte holds, the
// sequencer waits, and the queue fills before s_axis_tready drops.
module clock_date_lcd_formatter #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // hour format register: bit 0 = hour_format
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [4:0] hour, [10:5] minute, [16:11] second, [21:17] day_of_month,
  // [25:22] month_number, [32:26] year_offset, [33] alarm_active, [39:34] zero
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] lcd_byte
  output logic [7:0]  m_axis_tdata,
  // [0] is_character
  output logic        m_axis_tuser,
  output logic        m_axis_tlast
);

  cdlf_pkg::rec_t push_rec;
  cdlf_pkg::rec_t head_rec;
  logic           push;
  logic           q_full;
  logic           q_valid;
  logic           pop;

  cdlf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_rec_o (push_rec)
  );

  cdlf_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_rec_i(push_rec),
    .full_o    (q_full),
    .pop_i     (pop),
    .valid_o   (q_valid),
    .head_rec_o(head_rec)
  );

  cdlf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rec_valid_i  (q_valid),
    .rec_i        (head_rec),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_is_char_o(m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

endmodule

// ===== rtl/cdlf_front.sv =====
// Front end: hour format register, snapshot accept and digit classification.
module cdlf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cdlf_pkg::InDataW-1:0]  in_data_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output cdlf_pkg::rec_t                push_rec_o
);

  logic       hour_format_q, hour_format_d;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [5:0] second;
  logic [4:0] day;
  logic [3:0] month;
  logic [6:0] year;
  logic       alarm;
  logic [4:0] hour_disp;
  logic       pm;
  logic [6:0] year_low;
  logic       century;
  logic [7:0] hour_pair, min_pair, sec_pair, day_pair, mon_pair, year_pair;

  // Hold the display format until the next write
  assign hour_format_d = cfg_we_i ? cfg_wdata_i : hour_format_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_format_q <= 1'b0;
    end else begin
      hour_format_q <= hour_format_d;
    end
  end

  // Unpack the request fields
  assign hour   = in_data_i[4:0];
  assign minute = in_data_i[10:5];
  assign second = in_data_i[16:11];
  assign day    = in_data_i[21:17];
  assign month  = in_data_i[25:22];
  assign year   = in_data_i[32:26];
  assign alarm  = in_data_i[33];

  // In 12-hour mode map the hour to 12-hour form with AM/PM; in 24-hour mode pass it on
  always_comb begin
    hour_disp = hour;
    pm        = 1'b0;
    if (!hour_format_q) begin
      if (hour == 5'd0) begin
        hour_disp = cdlf_pkg::HalfDay;
      end else if (hour == cdlf_pkg::HalfDay) begin
        pm = 1'b1;
      end else if (hour > cdlf_pkg::HalfDay) begin
        hour_disp = hour - cdlf_pkg::HalfDay;
        pm        = 1'b1;
      end
    end
  end

  // Year 2000..2127: hundreds digit is 0 or 1
  assign century  = (year >= cdlf_pkg::Century);
  assign year_low = century ? (year - cdlf_pkg::Century) : year;

  assign hour_pair = cdlf_pkg::pair_digits({2'b00, hour_disp});
  assign min_pair  = cdlf_pkg::pair_digits({1'b0, minute});
  assign sec_pair  = cdlf_pkg::pair_digits({1'b0, second});
  assign day_pair  = cdlf_pkg::pair_digits({2'b00, day});
  assign mon_pair  = cdlf_pkg::pair_digits({3'b000, month});
  assign year_pair = cdlf_pkg::pair_digits(year_low);

  // Build the queued record
  always_comb begin
    push_rec_o.is24    = hour_format_q;
    push_rec_o.pm      = pm;
    push_rec_o.hour_t  = hour_pair[7:4];
    push_rec_o.hour_u  = hour_pair[3:0];
    push_rec_o.min_t   = min_pair[7:4];
    push_rec_o.min_u   = min_pair[3:0];
    push_rec_o.sec_t   = sec_pair[7:4];
    push_rec_o.sec_u   = sec_pair[3:0];
    push_rec_o.day_t   = day_pair[7:4];
    push_rec_o.day_u   = day_pair[3:0];
    push_rec_o.mon_t   = mon_pair[7:4];
    push_rec_o.mon_u   = mon_pair[3:0];
    push_rec_o.century = century;
    push_rec_o.year_t  = year_pair[7:4];
    push_rec_o.year_u  = year_pair[3:0];
    push_rec_o.alarm   = alarm;
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

// ===== rtl/cdlf_queue.sv =====
// Small register queue of classified snapshots between front and back end.
module cdlf_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cdlf_pkg::rec_t push_rec_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output cdlf_pkg::rec_t head_rec_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cdlf_pkg::rec_t      mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign head_rec_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // Advance pointers with wrap and track occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed record
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntW'(Depth))
    else $error("queue occupancy above depth");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (do_push && !do_pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count missed a push");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
    else $error("queue count missed a pop");

endmodule

// ===== rtl/cdlf_back.sv =====
// Back end: walks the display sequence of one snapshot into the output register.
module cdlf_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rec_valid_i,
  input  cdlf_pkg::rec_t                rec_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [cdlf_pkg::OutDataW-1:0] out_byte_o,
  output logic                          out_is_char_o,
  output logic                          out_last_o
);

  logic [cdlf_pkg::StepW-1:0] step_q, step_d;
  logic [cdlf_pkg::StepW-1:0] slot;
  logic [cdlf_pkg::StepW-1:0] last_slot;
  logic                       out_valid_q, out_valid_d;
  logic [7:0]                 out_byte_q, byte_d;
  logic                       out_is_char_q, is_char_d;
  logic                       out_last_q;
  logic                       out_free;
  logic                       fire;
  logic                       at_last;

  // 24-hour runs skip the AM/PM slots
  assign slot = (step_q == cdlf_pkg::StepAmPmCursor && rec_i.is24) ?
                cdlf_pkg::StepTimeCursor : step_q;
  assign last_slot = rec_i.alarm ? cdlf_pkg::StepStar : cdlf_pkg::StepYearU;
  assign at_last   = (slot == last_slot);
  assign out_free  = !out_valid_q || out_ready_i;
  assign fire      = rec_valid_i && out_free;
  assign pop_o     = fire && at_last;

  // Decode the byte of the current slot
  always_comb begin
    is_char_d = 1'b1;
    byte_d    = cdlf_pkg::ChSpace;
    unique case (slot)
      cdlf_pkg::StepAmPmCursor: begin
        is_char_d = 1'b0;
        byte_d    = cdlf_pkg::CmdRow0 | {4'b0000, cdlf_pkg::ColAmPm & cdlf_pkg::ColMask};
      end
      cdlf_pkg::StepAmPm:   byte_d = rec_i.pm ? cdlf_pkg::ChP : cdlf_pkg::ChA;
      cdlf_pkg::StepM:      byte_d = cdlf_pkg::ChM;
      cdlf_pkg::StepTimeCursor: begin
        is_char_d = 1'b0;
        byte_d    = cdlf_pkg::CmdRow0 |
                    {4'b0000, (rec_i.is24 ? cdlf_pkg::ColTime24 : cdlf_pkg::ColTime12) &
                              cdlf_pkg::ColMask};
      end
      cdlf_pkg::StepHourT:  byte_d = cdlf_pkg::digit_char(rec_i.hour_t);
      cdlf_pkg::StepHourU:  byte_d = cdlf_pkg::digit_char(rec_i.hour_u);
      cdlf_pkg::StepColon0: byte_d = cdlf_pkg::ChColon;
      cdlf_pkg::StepMinT:   byte_d = cdlf_pkg::digit_char(rec_i.min_t);
      cdlf_pkg::StepMinU:   byte_d = cdlf_pkg::digit_char(rec_i.min_u);
      cdlf_pkg::StepColon1: byte_d = cdlf_pkg::ChColon;
      cdlf_pkg::StepSecT:   byte_d = cdlf_pkg::digit_char(rec_i.sec_t);
      cdlf_pkg::StepSecU:   byte_d = cdlf_pkg::digit_char(rec_i.sec_u);
      cdlf_pkg::StepDateCursor: begin
        is_char_d = 1'b0;
        byte_d    = cdlf_pkg::CmdRow1 | {4'b0000, cdlf_pkg::ColDate & cdlf_pkg::ColMask};
      end
      cdlf_pkg::StepDayT:   byte_d = cdlf_pkg::digit_char(rec_i.day_t);
      cdlf_pkg::StepDayU:   byte_d = cdlf_pkg::digit_char(rec_i.day_u);
      cdlf_pkg::StepColon2: byte_d = cdlf_pkg::ChColon;
      cdlf_pkg::StepMonT:   byte_d = cdlf_pkg::digit_char(rec_i.mon_t);
      cdlf_pkg::StepMonU:   byte_d = cdlf_pkg::digit_char(rec_i.mon_u);
      cdlf_pkg::StepColon3: byte_d = cdlf_pkg::ChColon;
      cdlf_pkg::StepYearK:  byte_d = cdlf_pkg::ChTwo;
      cdlf_pkg::StepYearC:  byte_d = cdlf_pkg::digit_char({3'b000, rec_i.century});
      cdlf_pkg::StepYearT:  byte_d = cdlf_pkg::digit_char(rec_i.year_t);
      cdlf_pkg::StepYearU:  byte_d = cdlf_pkg::digit_char(rec_i.year_u);
      cdlf_pkg::StepSpace0: byte_d = cdlf_pkg::ChSpace;
      cdlf_pkg::StepSpace1: byte_d = cdlf_pkg::ChSpace;
      cdlf_pkg::StepStar:   byte_d = cdlf_pkg::ChStar;
      default:              byte_d = cdlf_pkg::ChSpace;
    endcase
  end

  // Advance the slot, restart at the end of a run
  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (fire) begin
      out_valid_d = 1'b1;
      step_d      = at_last ? cdlf_pkg::StepAmPmCursor : slot + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= cdlf_pkg::StepAmPmCursor;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_byte_q    <= byte_d;
      out_is_char_q <= is_char_d;
      out_last_q    <= at_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign out_is_char_o = out_is_char_q;
  assign out_last_o    = out_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && !out_is_char_q) |-> out_byte_q[7])
    else $error("cursor command without command bit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && out_last_q) |-> out_is_char_q)
    else $error("run ends on a command byte");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   step_q <= cdlf_pkg::StepStar)
    else $error("sequencer slot out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   pop_o |=> (step_q == cdlf_pkg::StepAmPmCursor))
    else $error("sequencer did not restart after a run");

endmodule

// ===== tb/clock_date_lcd_formatter_tb.sv =====
// Self-checking testbench for the clock/date LCD formatter: snapshots in, LCD byte runs out.
module clock_date_lcd_formatter_tb;

  localparam int HalfPeriod  = 5;
  localparam int ResetCycles = 6;
  localparam int CycleLimit  = 1_000_000;
  localparam int DrainCycles = 40;
  localparam int RandomPhases = 5;
  localparam int PhaseItems   = 80;
  localparam int MaxReported  = 10;

  // Hour format register values
  localparam logic Fmt12h = 1'b0;
  localparam logic Fmt24h = 1'b1;

  // LCD cursor commands, columns and characters
  localparam logic [7:0] Row0Cmd  = 8'h80;
  localparam logic [7:0] Row1Cmd  = 8'hC0;
  localparam logic [3:0] ColAmPm  = 4'd12;
  localparam logic [3:0] ColTm12  = 4'd3;
  localparam logic [3:0] ColTm24  = 4'd4;
  localparam logic [3:0] ColDate  = 4'd3;
  localparam int         DigitZero = 48;
  localparam int         YearBase  = 2000;
  localparam int         Noon      = 12;
  localparam logic [7:0] ChA      = 8'h41;
  localparam logic [7:0] ChP      = 8'h50;
  localparam logic [7:0] ChM      = 8'h4D;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChStar   = 8'h2A;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    StallNone,
    StallRandom,
    StallPeriodic,
    StallHoldOff
  } stall_mode_e;

  // One snapshot, packed as on s_axis_tdata (hour in the lowest bits)
  typedef struct packed {
    logic       alarm;
    logic [6:0] year;
    logic [3:0] month;
    logic [4:0] day;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
  } snap_t;

  // One LCD byte as seen on the master side
  typedef struct packed {
    logic [7:0] code;
    logic       is_char;
    logic       last;
  } lcd_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  snap_t     snapshots_to_send[$];
  lcd_byte_t lcd_bytes_due[$];
  logic      hour_format_now = Fmt12h;

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned snapshots_accepted = 0;
  int unsigned bytes_checked = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  int unsigned pattern_tick = 0;
  stall_mode_e stall_mode = StallNone;

  clock_date_lcd_formatter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // Count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d LCD bytes still due", cycle_count,
               lcd_bytes_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Append one cursor command to the expected bytes
  function automatic void due_cursor(logic [7:0] row_cmd, logic [3:0] col);
    lcd_bytes_due.push_back('{code: row_cmd | {4'h0, col}, is_char: 1'b0, last: 1'b0});
  endfunction

  // Append one character to the expected bytes
  function automatic void due_char(logic [7:0] ch);
    lcd_bytes_due.push_back('{code: ch, is_char: 1'b1, last: 1'b0});
  endfunction

  // Append a zero-padded two-digit decimal value
  function automatic void due_pair(int v);
    due_char(8'(DigitZero + (v % 100) / 10));
    due_char(8'(DigitZero + v % 10));
  endfunction

  // Work out the full LCD byte run that one snapshot must produce
  function automatic void predict_lcd_run(snap_t s, logic fmt);
    int        hr;
    int        yr;
    logic      pm;
    lcd_byte_t tail;
    hr = int'(s.hour);
    pm = 1'b0;
    if (fmt == Fmt12h) begin
      due_cursor(Row0Cmd, ColAmPm);
      if (hr == 0) begin
        hr = Noon;
      end else if (hr == Noon) begin
        pm = 1'b1;
      end else if (hr > Noon) begin
        hr = hr - Noon;
        pm = 1'b1;
      end
      due_char(pm ? ChP : ChA);
      due_char(ChM);
      due_cursor(Row0Cmd, ColTm12);
    end else begin
      due_cursor(Row0Cmd, ColTm24);
    end
    due_pair(hr);
    due_char(ChColon);
    due_pair(int'(s.minute));
    due_char(ChColon);
    due_pair(int'(s.second));
    due_cursor(Row1Cmd, ColDate);
    due_pair(int'(s.day));
    due_char(ChColon);
    due_pair(int'(s.month));
    due_char(ChColon);
    yr = YearBase + int'(s.year);
    due_char(8'(DigitZero + (yr / 1000) % 10));
    due_char(8'(DigitZero + (yr / 100) % 10));
    due_char(8'(DigitZero + (yr / 10) % 10));
    due_char(8'(DigitZero + yr % 10));
    if (s.alarm) begin
      due_char(ChSpace);
      due_char(ChSpace);
      due_char(ChStar);
    end
    // mark the final byte of the run
    tail = lcd_bytes_due.pop_back();
    tail.last = 1'b1;
    lcd_bytes_due.push_back(tail);
  endfunction

  function automatic snap_t make_snap(int h, int mi, int se, int d, int mo, int y, int a);
    snap_t s;
    s.hour   = 5'(h);
    s.minute = 6'(mi);
    s.second = 6'(se);
    s.day    = 5'(d);
    s.month  = 4'(mo);
    s.year   = 7'(y);
    s.alarm  = 1'(a);
    return s;
  endfunction

  // Mostly calendar-valid snapshots, some with any value the field widths allow
  function automatic snap_t random_snapshot();
    snap_t s;
    logic  wild;
    wild = ($urandom_range(0, 4) == 0);
    s.hour   = wild ? 5'($urandom) : 5'($urandom_range(0, 23));
    s.minute = wild ? 6'($urandom) : 6'($urandom_range(0, 59));
    s.second = wild ? 6'($urandom) : 6'($urandom_range(0, 59));
    s.day    = wild ? 5'($urandom) : 5'($urandom_range(1, 31));
    s.month  = wild ? 4'($urandom) : 4'($urandom_range(1, 12));
    s.year   = wild ? 7'($urandom) : 7'($urandom_range(0, 99));
    s.alarm  = 1'($urandom);
    return s;
  endfunction

  function automatic void flag_error(string msg);
    if (error_count < MaxReported) begin
      $display("ERROR at cycle %0d: %s", cycle_count, msg);
    end
    error_count++;
  endfunction

  // Write the hour format register while the block is idle
  task automatic write_hour_format(logic fmt);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= fmt;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    hour_format_now = fmt;
  endtask

  // Hold until every snapshot is accepted and every byte has arrived
  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (snapshots_to_send.size() != 0 || s_axis_tvalid || lcd_bytes_due.size() != 0);
  endtask

  // Send snapshots in bursts with random gaps; predict each accepted request
  always @(posedge clk_i) begin : drive_snapshots
    logic        nxt_valid;
    logic [39:0] nxt_data;
    nxt_valid = s_axis_tvalid;
    nxt_data  = s_axis_tdata;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_lcd_run(snap_t'(s_axis_tdata[33:0]), hour_format_now);
        snapshots_accepted++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (snapshots_to_send.size() != 0) begin
          nxt_valid = 1'b1;
          nxt_data  = {6'b0, snapshots_to_send.pop_front()};
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
          end else begin
            burst_left--;
          end
        end
      end
    end
    s_axis_tvalid <= nxt_valid;
    s_axis_tdata  <= nxt_data;
  end

  // Check each accepted LCD byte and drive the receiver stall pattern
  always @(posedge clk_i) begin : receive_lcd_bytes
    logic      nxt_ready;
    lcd_byte_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      bytes_checked++;
      if (lcd_bytes_due.size() == 0) begin
        flag_error($sformatf("unexpected byte %02h user %0b last %0b", m_axis_tdata,
                             m_axis_tuser, m_axis_tlast));
      end else begin
        want = lcd_bytes_due.pop_front();
        if (m_axis_tdata !== want.code || m_axis_tuser !== want.is_char ||
            m_axis_tlast !== want.last) begin
          flag_error($sformatf("byte %02h user %0b last %0b, expected %02h user %0b last %0b",
                               m_axis_tdata, m_axis_tuser, m_axis_tlast,
                               want.code, want.is_char, want.last));
        end
      end
    end
    // switch stall pattern now and then
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    pattern_tick++;
    case (stall_mode)
      StallNone: begin
        nxt_ready = 1'b1;
      end
      StallRandom: begin
        nxt_ready = 1'($urandom);
      end
      StallPeriodic: begin
        nxt_ready = (pattern_tick % 3) != 0;
      end
      default: begin
        if (hold_left != 0) begin
          hold_left--;
          nxt_ready = 1'b0;
        end else begin
          nxt_ready = 1'b1;
          if ($urandom_range(0, 5) == 0) hold_left = $urandom_range(1, 12);
        end
      end
    endcase
    m_axis_tready <= nxt_ready;
  end

  // Reset, directed snapshots in both formats, then random phases
  initial begin
    snap_t directed[$];
    int    phase;
    int    i;
    directed.push_back(make_snap(0, 0, 0, 1, 1, 0, 0));       // midnight, 12 AM
    directed.push_back(make_snap(11, 59, 59, 31, 12, 99, 1)); // last AM hour
    directed.push_back(make_snap(12, 30, 5, 15, 6, 50, 0));   // noon is PM
    directed.push_back(make_snap(13, 1, 2, 3, 4, 5, 1));      // first hour with 12 removed
    directed.push_back(make_snap(23, 45, 9, 28, 2, 24, 0));   // last valid hour
    directed.push_back(make_snap(31, 63, 63, 31, 15, 127, 1)); // every field at its top
    directed.push_back(make_snap(0, 0, 0, 0, 0, 0, 0));       // every field zero
    directed.push_back(make_snap(1, 9, 10, 9, 10, 9, 1));    // digit carries
    directed.push_back(make_snap(24, 0, 59, 1, 12, 100, 0));  // hour past the day, year 2100
    directed.push_back(make_snap(20, 10, 20, 10, 9, 1, 1));

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_hour_format(Fmt12h);
    foreach (directed[i]) snapshots_to_send.push_back(directed[i]);
    wait_idle();
    write_hour_format(Fmt24h);
    foreach (directed[i]) snapshots_to_send.push_back(directed[i]);
    wait_idle();

    for (phase = 0; phase < RandomPhases; phase++) begin
      write_hour_format((phase % 2 == 0) ? Fmt12h : Fmt24h);
      for (i = 0; i < PhaseItems; i++) snapshots_to_send.push_back(random_snapshot());
      wait_idle();
    end

    // let any stray byte show up before the verdict
    repeat (DrainCycles) @(posedge clk_i);
    $display("Ran %0d snapshots through 12-hour and 24-hour phases; %0d LCD bytes checked.",
             snapshots_accepted, bytes_checked);
    $display("Mismatches or unexpected bytes: %0d", error_count);
    if (error_count == 0 && lcd_bytes_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
